@@ rtl/core/aesctr_pkg.sv @@
package aesctr_pkg;

    localparam int unsigned BlockBytes    = 16;
    localparam int unsigned ScheduleWords = 60;
    localparam int unsigned QueueDepth    = 2;
    localparam logic [7:0]  PadByte       = 8'h2E;

    // configuration register indexes
    localparam logic [2:0] RegKey0   = 3'd0;
    localparam logic [2:0] RegKey1   = 3'd1;
    localparam logic [2:0] RegKey2   = 3'd2;
    localparam logic [2:0] RegKey3   = 3'd3;
    localparam logic [2:0] RegKeyLen = 3'd4;
    localparam logic [2:0] RegIvHigh = 3'd5;
    localparam logic [2:0] RegIvLow  = 3'd6;

    // key length codes
    localparam logic [1:0] KeyLen128 = 2'd0;
    localparam logic [1:0] KeyLen192 = 2'd1;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  valid_bytes;
        logic        first_block;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_beat_t;

    // one queued job: padded data and the counter to encrypt
    typedef struct packed {
        logic [127:0] data;
        logic [127:0] ctr;
    } job_t;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [1:0]  key_len;
    } key_cfg_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // subbytes, shiftrows and optional mixcolumns; byte 0 in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = sbox(s[127 - 8 * i -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                t[4 * c + k] = b[4 * ((c + k) % 4) + k];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (mix)
            begin
                t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127 - 8 * i -: 8] = t[i];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/aes_ctr_block_cipher.sv @@
// channel | signals                       | accepted when
// in      | in_valid, in_stall, in_data   | in_valid && !in_stall
// out     | out_valid, out_stall, out_data| out_valid && !out_stall
// cfg     | cfg_we, cfg_index, cfg_data   | cfg_we
// the front pads beats and queues them with their counter, two beats deep
// the back runs the rounds for 128, 192 or 256-bit keys, one beat at a time
// each round waits on four single-port key word reads
// a key change costs one schedule expansion first, a read and a write per word
// out_stall holds the finished beat in the back; in_stall rises while the queue is full
// reset clears the counter, queue and key-ready flag; key schedule is rebuilt
module aes_ctr_block_cipher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  aesctr_pkg::in_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output aesctr_pkg::out_beat_t out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    aesctr_pkg::key_cfg_t key_cfg_reg;
    logic [63:0]          iv_high_reg, iv_low_reg;
    logic                 key_dirty;
    logic                 job_valid, job_pop;
    aesctr_pkg::job_t     job;

    assign key_dirty = cfg_we && (cfg_index <= aesctr_pkg::RegKeyLen);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cfg_reg <= '0;
            iv_high_reg <= '0;
            iv_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aesctr_pkg::RegKey0:   key_cfg_reg.key0    <= cfg_data;
                aesctr_pkg::RegKey1:   key_cfg_reg.key1    <= cfg_data;
                aesctr_pkg::RegKey2:   key_cfg_reg.key2    <= cfg_data;
                aesctr_pkg::RegKey3:   key_cfg_reg.key3    <= cfg_data;
                aesctr_pkg::RegKeyLen: key_cfg_reg.key_len <= cfg_data[1:0];
                aesctr_pkg::RegIvHigh: iv_high_reg         <= cfg_data;
                aesctr_pkg::RegIvLow:  iv_low_reg          <= cfg_data;
                default: ;
            endcase
        end
    end

    aesctr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_data),
        .iv_high   (iv_high_reg),
        .iv_low    (iv_low_reg),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    aesctr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_cfg   (key_cfg_reg),
        .key_dirty (key_dirty),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_data)
    );

endmodule

@@ rtl/core/aesctr_front.sv @@
module aesctr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  aesctr_pkg::in_beat_t in_beat,
    input  logic [63:0]         iv_high,
    input  logic [63:0]         iv_low,
    output logic                job_valid,
    input  logic                job_pop,
    output aesctr_pkg::job_t    job
);

    localparam int unsigned PtrW = $clog2(aesctr_pkg::QueueDepth);

    aesctr_pkg::job_t      q_mem [aesctr_pkg::QueueDepth];
    logic [PtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]         count_reg;
    logic [127:0]          ctr_reg;
    logic [127:0]          ctr_use;
    logic [127:0]          data_pad;
    logic                  push;

    assign in_stall  = (count_reg == (PtrW+1)'(aesctr_pkg::QueueDepth));
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != '0);
    assign job       = q_mem[rd_ptr_reg];

    // counter source: iv on a first beat
    assign ctr_use = in_beat.first_block ? {iv_high, iv_low} : ctr_reg;

    // pad short blocks
    always_comb
    begin
        data_pad = {in_beat.block_high, in_beat.block_low};
        if (in_beat.valid_bytes >= 5'd1 && in_beat.valid_bytes < 5'd16)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (5'(i) >= in_beat.valid_bytes)
                begin
                    data_pad[127 - 8 * i -: 8] = aesctr_pkg::PadByte;
                end
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{data: data_pad, ctr: ctr_use};
        end
    end

    // queue pointers and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            ctr_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                ctr_reg    <= ctr_use + 128'd1;
            end
            if (job_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(job_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid) else $error("pop of empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PtrW+1)'(aesctr_pkg::QueueDepth)) else $error("queue overflow");
    a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> ctr_reg == $past(ctr_use) + 128'd1) else $error("counter step");
`endif

endmodule

@@ rtl/core/aesctr_back.sv @@
module aesctr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aesctr_pkg::key_cfg_t  key_cfg,
    input  logic                  key_dirty,
    input  logic                  job_valid,
    output logic                  job_pop,
    input  aesctr_pkg::job_t      job,
    output logic                  out_valid,
    input  logic                  out_stall,
    output aesctr_pkg::out_beat_t out_beat
);

    typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_LOAD, S_ROUND, S_DONE} state_t;

    state_t          state_reg;
    logic [31:0]     rk_mem [aesctr_pkg::ScheduleWords];
    logic [5:0]      wi_reg;
    logic [31:0]     prev_reg;
    logic [3:0]      nk_cnt_reg;
    logic [7:0]      rcon_reg;
    logic            ready_reg;
    logic [3:0]      round_reg;
    logic [1:0]      col_reg;
    logic            phase_reg;
    logic [127:0]    state_v_reg;
    logic [127:0]    rk_buf_reg;
    logic [127:0]    data_reg;
    logic [127:0]    ctr_reg;
    logic [31:0]     rk_rd_reg;
    logic            out_valid_reg;
    logic [127:0]    out_reg;

    logic [3:0]      nr;
    logic [3:0]      nk;
    logic [5:0]      total;
    logic [31:0]     t_word;
    logic [31:0]     new_word;
    logic [5:0]      rd_addr;
    logic [63:0]     kw;

    always_comb
    begin
        unique case (key_cfg.key_len)
            aesctr_pkg::KeyLen128: nr = 4'd10;
            aesctr_pkg::KeyLen192: nr = 4'd12;
            default:               nr = 4'd14;
        endcase
    end
    assign nk    = nr - 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    // key word for direct load
    always_comb
    begin
        case (wi_reg[2:1])
            2'd0:    kw = key_cfg.key0;
            2'd1:    kw = key_cfg.key1;
            2'd2:    kw = key_cfg.key2;
            default: kw = key_cfg.key3;
        endcase
    end

    // schedule step: one word per read and write pair
    always_comb
    begin
        t_word = prev_reg;
        if (nk_cnt_reg == 4'd0)
        begin
            t_word = aesctr_pkg::sub_word({prev_reg[23:0], prev_reg[31:24]}) ^ {rcon_reg, 24'd0};
        end
        else if (nk == 4'd8 && nk_cnt_reg == 4'd4)
        begin
            t_word = aesctr_pkg::sub_word(prev_reg);
        end
        new_word = (wi_reg < 6'(nk)) ? (wi_reg[0] ? kw[31:0] : kw[63:32])
                                     : (rk_rd_reg ^ t_word);
    end

    assign job_pop   = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;
    assign out_beat  = '{cipher_high: out_reg[127:64], cipher_low: out_reg[63:0]};
    assign rd_addr   = (state_reg == S_EXPAND) ? (wi_reg - 6'(nk))
                                               : {round_reg, col_reg};

    // schedule memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXPAND && phase_reg)
        begin
            rk_mem[wi_reg] <= new_word;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            wi_reg        <= '0;
            phase_reg     <= 1'b0;
            round_reg     <= '0;
            col_reg       <= '0;
            nk_cnt_reg    <= '0;
            rcon_reg      <= '0;
            prev_reg      <= '0;
            state_v_reg   <= '0;
            rk_buf_reg    <= '0;
            data_reg      <= '0;
            ctr_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (key_dirty)
            begin
                ready_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && !key_dirty)
                    begin
                        if (!ready_reg)
                        begin
                            state_reg  <= S_EXPAND;
                            wi_reg     <= '0;
                            phase_reg  <= 1'b0;
                            nk_cnt_reg <= '0;
                            rcon_reg   <= 8'h01;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_EXPAND:
                begin
                    // phase 0 reads w[i-nk], phase 1 writes w[i]
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        prev_reg <= new_word;
                        if (wi_reg >= 6'(nk))
                        begin
                            if (nk_cnt_reg == 4'd0)
                            begin
                                rcon_reg <= aesctr_pkg::xtime(rcon_reg);
                            end
                        end
                        nk_cnt_reg <= (nk_cnt_reg == nk - 4'd1) ? 4'd0 : nk_cnt_reg + 4'd1;
                        if (wi_reg == total - 6'd1)
                        begin
                            ready_reg <= 1'b1;
                            state_reg <= S_LOAD;
                        end
                        wi_reg <= wi_reg + 6'd1;
                    end
                end
                S_LOAD:
                begin
                    data_reg    <= job.data;
                    ctr_reg     <= job.ctr;
                    round_reg   <= '0;
                    col_reg     <= '0;
                    state_reg   <= S_ROUND;
                    phase_reg   <= 1'b0;
                end
                S_ROUND:
                begin
                    // fetch four key words, one per cycle, then apply the round
                    col_reg <= col_reg + 2'd1;
                    if (phase_reg)
                    begin
                        rk_buf_reg <= {rk_buf_reg[95:0], rk_rd_reg};
                    end
                    phase_reg <= 1'b1;
                    if (col_reg == 2'd0 && phase_reg)
                    begin
                        if (round_reg == 4'd1)
                        begin
                            state_v_reg <= ctr_reg ^ {rk_buf_reg[95:0], rk_rd_reg};
                        end
                        else
                        begin
                            // last round skips mixcolumns
                            state_v_reg <= aesctr_pkg::aes_round(state_v_reg,
                                                                 round_reg != nr + 4'd1)
                                           ^ {rk_buf_reg[95:0], rk_rd_reg};
                        end
                        if (round_reg == nr + 4'd1)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    if (col_reg == 2'd3)
                    begin
                        round_reg <= round_reg + 4'd1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg       <= data_reg ^ state_v_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid) else $error("load without job");
    a_ready_only_expand: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(state_reg) == S_EXPAND) else $error("keys ready early");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg) else $error("result dropped");
`endif

endmodule

@@ sim/aes_ctr_block_cipher_test.sv @@
`timescale 1ns / 100ps

module aes_ctr_block_cipher_test;

    localparam int SettleCycles = 300;
    localparam int StallLimit   = 3000;
    localparam logic [1:0] KeyLen256  = 2'd2;
    localparam logic [1:0] KeyLenSpare = 2'd3;
    localparam logic [2:0] RegUnused = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    aesctr_pkg::in_beat_t  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    aesctr_pkg::out_beat_t out_data;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [63:0]           cfg_data = '0;

    aesctr_pkg::in_beat_t  pending_blocks [$];
    aesctr_pkg::out_beat_t expected_cipher [$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          error_count = 0;
    int          blocks_sent = 0;
    int          blocks_checked = 0;
    int          quiet_cycles = 0;

    // mirror of the block's registers and state
    logic [63:0]  key_mirror [4];
    logic [1:0]   key_len_mirror;
    logic [63:0]  iv_high_mirror;
    logic [63:0]  iv_low_mirror;
    logic [127:0] counter_mirror;
    logic [31:0]  round_keys [60];
    logic         schedule_fresh;
    logic [7:0]   sub_table [256];

    aes_ctr_block_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // gf(2^8) helpers for building the s-box
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic void build_sub_table();
        logic [7:0] inv;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'd1;
            for (int i = 0; i < 254; i++)
                inv = gf_mul(inv, x[7:0]);
            sub_table[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                         ^ rotl8(inv, 4) ^ 8'h63;
        end
    endfunction

    function automatic int round_count();
        return (key_len_mirror == aesctr_pkg::KeyLen128) ? 10 :
               (key_len_mirror == aesctr_pkg::KeyLen192) ? 12 : 14;
    endfunction

    function automatic logic [31:0] sub_word32(input logic [31:0] w);
        return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]],
                sub_table[w[7:0]]};
    endfunction

    // key schedule expansion for the selected key length
    function automatic void expand_schedule();
        int nk;
        int total;
        logic [7:0] rcon;
        logic [31:0] t;
        nk = round_count() - 6;
        total = 4 * (round_count() + 1);
        rcon = 8'd1;
        for (int i = 0; i < nk; i++)
            round_keys[i] = i[0] ? key_mirror[i >> 1][31:0] : key_mirror[i >> 1][63:32];
        for (int i = nk; i < total; i++)
        begin
            t = round_keys[i - 1];
            if (i % nk == 0)
            begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rcon, 24'd0};
                rcon = gf_double(rcon);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_word32(t);
            round_keys[i] = round_keys[i - nk] ^ t;
        end
        schedule_fresh = 1'b1;
    endfunction

    function automatic logic [127:0] round_key_block(input int r);
        return {round_keys[4 * r], round_keys[4 * r + 1], round_keys[4 * r + 2],
                round_keys[4 * r + 3]};
    endfunction

    function automatic logic [127:0] keystream_of(input logic [127:0] ctr);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] st;
        st = ctr ^ round_key_block(0);
        for (int r = 1; r <= round_count(); r++)
        begin
            for (int i = 0; i < 16; i++)
                b[i] = sub_table[st[127 - 8 * i -: 8]];
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    t[4 * c + k] = b[4 * ((c + k) % 4) + k];
            if (r != round_count())
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c];
                    a1 = t[4 * c + 1];
                    a2 = t[4 * c + 2];
                    a3 = t[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                    t[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    t[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    t[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[127 - 8 * i -: 8] = t[i];
            st ^= round_key_block(r);
        end
        return st;
    endfunction

    // expected cipher block for one accepted beat, advancing the counter
    function automatic aesctr_pkg::out_beat_t cipher_of(input aesctr_pkg::in_beat_t beat);
        logic [127:0] data;
        logic [127:0] ks;
        aesctr_pkg::out_beat_t res;
        if (beat.first_block)
            counter_mirror = {iv_high_mirror, iv_low_mirror};
        if (!schedule_fresh)
            expand_schedule();
        data = {beat.block_high, beat.block_low};
        if (beat.valid_bytes >= 1 && beat.valid_bytes < 16)
            for (int i = beat.valid_bytes; i < 16; i++)
                data[127 - 8 * i -: 8] = aesctr_pkg::PadByte;
        ks = keystream_of(counter_mirror);
        {res.cipher_high, res.cipher_low} = data ^ ks;
        counter_mirror = counter_mirror + 128'd1;
        return res;
    endfunction

    // input driver and prediction of accepted beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_cipher.push_back(cipher_of(in_data));
                blocks_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= pending_blocks.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_cipher.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, out_data);
                    error_count++;
                end
                else
                begin
                    if (out_data.cipher_high !== expected_cipher[0].cipher_high)
                    begin
                        $display("%0t: cipher_high expected %h got %h", $time,
                                 expected_cipher[0].cipher_high, out_data.cipher_high);
                        error_count++;
                    end
                    if (out_data.cipher_low !== expected_cipher[0].cipher_low)
                    begin
                        $display("%0t: cipher_low expected %h got %h", $time,
                                 expected_cipher[0].cipher_low, out_data.cipher_low);
                        error_count++;
                    end
                    void'(expected_cipher.pop_front());
                    blocks_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no beat accepted and no register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: timeout, %0d beats outstanding", $time, expected_cipher.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_blocks.size() > 0 || in_valid || expected_cipher.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx < aesctr_pkg::RegKeyLen)
            key_mirror[idx[1:0]] = value;
        if (idx == aesctr_pkg::RegKeyLen)
            key_len_mirror = value[1:0];
        if (idx == aesctr_pkg::RegIvHigh)
            iv_high_mirror = value;
        if (idx == aesctr_pkg::RegIvLow)
            iv_low_mirror = value;
        if (idx <= aesctr_pkg::RegKeyLen)
            schedule_fresh = 1'b0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [1:0] len, input logic [63:0] ivh,
                              input logic [63:0] ivl);
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        write_reg(aesctr_pkg::RegKey0, k0);
        write_reg(aesctr_pkg::RegKey1, k1);
        write_reg(aesctr_pkg::RegKey2, k2);
        write_reg(aesctr_pkg::RegKey3, k3);
        write_reg(aesctr_pkg::RegKeyLen, {62'd0, len});
        write_reg(aesctr_pkg::RegIvHigh, ivh);
        write_reg(aesctr_pkg::RegIvLow, ivl);
    endtask

    task automatic push_block(input logic [127:0] data, input int vb, input logic first);
        aesctr_pkg::in_beat_t beat;
        beat.block_high = data[127:64];
        beat.block_low = data[63:0];
        beat.valid_bytes = vb[4:0];
        beat.first_block = first;
        pending_blocks.push_back(beat);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // a message of random content, or now and then a stray beat
    task automatic push_message();
        int len;
        if ($urandom_range(9) == 0)
            push_block({rand64(), rand64()}, $urandom_range(31), 1'($urandom_range(1)));
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_block({rand64(), rand64()},
                           (i == len - 1) ? $urandom_range(1, 16) : 16, i == 0);
        end
    endtask

    initial
    begin
        int target;
        build_sub_table();
        for (int i = 0; i < 4; i++)
            key_mirror[i] = '0;
        key_len_mirror = aesctr_pkg::KeyLen128;
        iv_high_mirror = '0;
        iv_low_mirror = '0;
        counter_mirror = '0;
        schedule_fresh = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no first block yet, then padding lengths and field extremes
        push_block('0, 16, 1'b0);
        push_block({128{1'b1}}, 0, 1'b0);
        load_setup(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0,
                   aesctr_pkg::KeyLen128, 64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff);
        push_block({128{1'b1}}, 1, 1'b1);
        push_block({128{1'b1}}, 15, 1'b0);
        push_block({128{1'b1}}, 16, 1'b0);
        push_block({128{1'b1}}, 17, 1'b0);
        push_block({128{1'b1}}, 31, 1'b0);
        push_block('0, 8, 1'b1);

        // counter wrap from all ones (192-bit key), carry into the high iv word (256-bit), spare length code
        load_setup({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, aesctr_pkg::KeyLen192,
                   {64{1'b1}}, {64{1'b1}} - 1);
        write_reg(RegUnused, 64'h0123456789abcdef);
        push_block('0, 16, 1'b1);
        push_block('0, 16, 1'b0);
        push_block('0, 16, 1'b0);
        load_setup(rand64(), rand64(), rand64(), rand64(), KeyLen256, '0, {64{1'b1}});
        push_block({rand64(), rand64()}, 3, 1'b1);
        push_block({rand64(), rand64()}, 16, 1'b0);
        load_setup(rand64(), rand64(), rand64(), rand64(), KeyLenSpare, rand64(), rand64());
        push_block({rand64(), rand64()}, 16, 1'b1);
        push_block({rand64(), rand64()}, 12, 1'b0);

        // random phases: each a new key setup and idling pattern
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                load_setup(rand64(), rand64(), rand64(), rand64(), 2'(p % 4),
                           {64{1'b1}}, {64{1'b1}} - 2);
            else
                load_setup(rand64(), rand64(), rand64(), rand64(), 2'(p % 4),
                           rand64(), rand64());
            send_idle_pct = (p % 4 == 1) ? 50 : (p % 4 == 3) ? 17 : 0;
            stall_pct = (p % 4 == 2) ? 50 : (p % 4 == 3) ? 17 : 0;
            target = blocks_sent + pending_blocks.size() + 90;
            while (blocks_sent + pending_blocks.size() < target)
                push_message();
            // sender holds off until the block has drained
            wait_drained();
            target = blocks_sent + 90;
            while (blocks_sent + pending_blocks.size() < target)
                push_message();
        end

        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        $display("%0d blocks sent, %0d checked, %0d mismatches", blocks_sent,
                 blocks_checked, error_count);
        $display("covered all key lengths, short and oversize blocks, counter wrap");
        if (error_count == 0 && expected_cipher.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
